// ===== design/lbd_pkg.sv =====
// Shared constants and types for the LZSS block decompressor.
// Used by lbd_ring, lbd_parser and lzss_block_decompressor_top; no dependencies.
package lbd_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int MAX_MATCH   = 18;
    localparam int COUNT_BITS  = 24;
    localparam int MATCH_BIAS  = 3;

    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int LEN_W       = $clog2(MAX_MATCH + 1);
    localparam int REM_W       = 15;

    localparam logic [RING_AW-1:0]    RING_START = RING_AW'(RING_DEPTH - MAX_MATCH);
    localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(RING_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [7:0]            SPACE_CHAR = 8'h20;
    localparam logic [7:0]            FLAG_SENTINEL = 8'hFF;

    // Commands from the parser to the ring memory.
    typedef struct packed {
        logic               restart;
        logic               wr_en;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_cmd;

    // One output byte handed to the output register.
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_emit;

endpackage

// ===== design/lbd_ring.sv =====
// History ring of the decompressor: 4096 x 8 synchronous memory with a fill count.
// Depends on lbd_pkg for widths and the command struct.
module lbd_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lbd_pkg::t_ring_cmd i_cmd,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [lbd_pkg::RING_DEPTH];
    logic [7:0] r_q;
    logic [7:0] r_fwd;
    logic       r_hit;
    logic       r_vld;

    logic [lbd_pkg::RING_AW-1:0] r_wp, n_wp;
    logic [lbd_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic [lbd_pkg::RING_AW-1:0] rd_off;

    // Writes since the last restart form one contiguous run starting at RING_START,
    // so an entry is live exactly when its offset from there is below the fill count.
    assign rd_off = i_cmd.rd_addr - lbd_pkg::RING_START;

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (i_cmd.restart) begin
            n_wp   = lbd_pkg::RING_START;
            n_fill = '0;
        end else if (i_cmd.wr_en) begin
            n_wp = r_wp + 1'b1;
            if (r_fill != lbd_pkg::FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= lbd_pkg::RING_START;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_wp] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_q <= r_mem[i_cmd.rd_addr];
        end
    end

    // A read of the entry being written in the same cycle takes the new byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_hit <= i_cmd.wr_en && (i_cmd.rd_addr == r_wp);
            r_fwd <= i_cmd.wr_data;
            r_vld <= ({1'b0, rd_off} < r_fill);
        end
    end

    assign o_rd_data = r_hit ? r_fwd : (r_vld ? r_q : lbd_pkg::SPACE_CHAR);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lbd_pkg::FILL_FULL)
        else $error("ring fill count above depth");

    a_restart_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |=> (r_fill == '0) && (r_wp == lbd_pkg::RING_START))
        else $error("ring restart did not reset pointer and fill");

    a_wp_follows_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != lbd_pkg::FILL_FULL) |->
            (r_wp == lbd_pkg::RING_AW'(lbd_pkg::RING_START + r_fill[lbd_pkg::RING_AW-1:0])))
        else $error("write pointer out of step with fill count");
`endif

endmodule

// ===== design/lbd_parser.sv =====
// Stream parser and match copy sequencer: block headers, flag bytes, literals,
// and ring copies. Depends on lbd_pkg; drives lbd_ring through t_ring_cmd.
module lbd_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_cfg_we,
    input  logic [lbd_pkg::COUNT_BITS-1:0]  i_cfg_data,
    input  logic                            i_can_emit,
    input  logic [7:0]                      i_ring_data,
    output lbd_pkg::t_ring_cmd              o_ring_cmd,
    output lbd_pkg::t_emit                  o_emit
);

    typedef enum logic [2:0] {
        ST_HDR_HI,
        ST_HDR_LO,
        ST_STORED,
        ST_NEXT,
        ST_TOKEN,
        ST_MATCH_HI,
        ST_COPY
    } t_state;

    t_state                         r_state, n_state;
    logic [7:0]                     r_held, n_held;
    logic [lbd_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [15:0]                    r_flag, n_flag;
    logic [lbd_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [lbd_pkg::COUNT_BITS-1:0] r_total, n_total;
    logic [lbd_pkg::RING_AW-1:0]    r_rd_addr, n_rd_addr;
    logic [lbd_pkg::LEN_W-1:0]      r_reads, n_reads;
    logic [lbd_pkg::LEN_W-1:0]      r_emits, n_emits;
    logic                           r_pend, n_pend;
    logic                           r_end, n_end;

    logic                           acc;
    logic [lbd_pkg::COUNT_BITS-1:0] cnt_inc;
    logic [lbd_pkg::REM_W-1:0]      rem_dec;
    logic                           blk_end;

    assign o_in_ready = (r_state != ST_COPY) && i_can_emit;
    assign acc        = i_in_valid && o_in_ready;
    assign cnt_inc    = (r_count == lbd_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    assign rem_dec    = r_rem - 1'b1;
    assign blk_end    = (rem_dec == '0);

    always_comb begin
        logic [15:0] hdr;
        logic [15:0] shifted;
        logic        do_tok;
        logic        tok_bit;
        logic        issue;
        logic        last;

        hdr       = {r_held, i_in_byte};
        shifted   = {1'b0, r_flag[15:1]};
        do_tok    = 1'b0;
        tok_bit   = 1'b0;
        issue     = 1'b0;
        last      = 1'b0;

        n_state   = r_state;
        n_held    = r_held;
        n_rem     = r_rem;
        n_flag    = r_flag;
        n_count   = r_count;
        n_total   = i_cfg_we ? i_cfg_data : r_total;
        n_rd_addr = r_rd_addr;
        n_reads   = r_reads;
        n_emits   = r_emits;
        n_pend    = r_pend;
        n_end     = r_end;

        o_ring_cmd         = '0;
        o_ring_cmd.rd_addr = r_rd_addr;
        o_emit             = '0;

        unique case (r_state)
            ST_HDR_HI: begin
                // Once the expected total is reached, further input is swallowed.
                if (acc && (r_count < r_total)) begin
                    n_held  = i_in_byte;
                    n_state = ST_HDR_LO;
                end
            end
            ST_HDR_LO: begin
                if (acc) begin
                    n_rem = hdr[lbd_pkg::REM_W-1:0];
                    if (!hdr[15]) begin
                        o_ring_cmd.restart = 1'b1;
                        n_flag             = '0;
                    end
                    if (hdr[lbd_pkg::REM_W-1:0] == '0) begin
                        n_state = ST_HDR_HI;
                    end else begin
                        n_state = hdr[15] ? ST_STORED : ST_NEXT;
                    end
                end
            end
            ST_STORED: begin
                if (acc) begin
                    n_rem        = rem_dec;
                    o_emit.vld   = 1'b1;
                    o_emit.data  = i_in_byte;
                    last         = 1'b1;
                    if (blk_end) begin
                        n_state = ST_HDR_HI;
                    end
                end
            end
            ST_NEXT: begin
                if (acc) begin
                    n_rem = rem_dec;
                    // The sentinel high byte marks when eight flags have been used.
                    if (!shifted[8]) begin
                        n_flag  = {lbd_pkg::FLAG_SENTINEL, i_in_byte};
                        n_state = blk_end ? ST_HDR_HI : ST_TOKEN;
                    end else begin
                        n_flag  = shifted;
                        do_tok  = 1'b1;
                        tok_bit = shifted[0];
                    end
                end
            end
            ST_TOKEN: begin
                if (acc) begin
                    n_rem   = rem_dec;
                    do_tok  = 1'b1;
                    tok_bit = r_flag[0];
                end
            end
            ST_MATCH_HI: begin
                if (acc) begin
                    n_rem     = rem_dec;
                    n_rd_addr = {i_in_byte[7:4], r_held};
                    n_reads   = lbd_pkg::LEN_W'(i_in_byte[3:0]) +
                                lbd_pkg::LEN_W'(lbd_pkg::MATCH_BIAS);
                    n_emits   = lbd_pkg::LEN_W'(i_in_byte[3:0]) +
                                lbd_pkg::LEN_W'(lbd_pkg::MATCH_BIAS);
                    n_pend    = 1'b0;
                    n_end     = blk_end;
                    n_state   = ST_COPY;
                end
            end
            ST_COPY: begin
                // One byte per cycle while the output has room: the read issued now returns next cycle,
                // and the byte is emitted and written back at the ring's write pointer once it has room.
                if (r_pend && i_can_emit) begin
                    o_emit.vld         = 1'b1;
                    o_emit.data        = i_ring_data;
                    o_ring_cmd.wr_en   = 1'b1;
                    o_ring_cmd.wr_data = i_ring_data;
                    n_emits            = r_emits - 1'b1;
                    last               = (r_emits == lbd_pkg::LEN_W'(1));
                    if (last) begin
                        n_state = r_end ? ST_HDR_HI : ST_NEXT;
                    end
                end
                issue = (r_reads != '0) && (!r_pend || i_can_emit);
                if (issue) begin
                    o_ring_cmd.rd_en = 1'b1;
                    n_rd_addr        = r_rd_addr + 1'b1;
                    n_reads          = r_reads - 1'b1;
                end
                n_pend = issue || (r_pend && !i_can_emit);
            end
            default: begin
                n_state = ST_HDR_HI;
            end
        endcase

        if (do_tok) begin
            if (tok_bit) begin
                o_emit.vld         = 1'b1;
                o_emit.data        = i_in_byte;
                o_ring_cmd.wr_en   = 1'b1;
                o_ring_cmd.wr_data = i_in_byte;
                last               = 1'b1;
                n_state            = ST_NEXT;
            end else begin
                n_held  = i_in_byte;
                n_state = ST_MATCH_HI;
            end
            // A token cut off by the block's end is dropped here.
            if (blk_end) begin
                n_state = ST_HDR_HI;
            end
        end

        if (o_emit.vld) begin
            n_count     = cnt_inc;
            o_emit.last = last;
            o_emit.done = last && ((r_state == ST_COPY) ? r_end : blk_end) &&
                          (cnt_inc >= r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR_HI;
            r_held  <= '0;
            r_rem   <= '0;
            r_flag  <= '0;
            r_count <= '0;
            r_total <= '0;
            r_reads <= '0;
            r_emits <= '0;
            r_pend  <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_rem   <= n_rem;
            r_flag  <= n_flag;
            r_count <= n_count;
            r_total <= n_total;
            r_reads <= n_reads;
            r_emits <= n_emits;
            r_pend  <= n_pend;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
    end

`ifndef SYNTHESIS
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.vld |-> i_can_emit)
        else $error("byte emitted while the output register is full");

    a_reads_lead_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |->
            ((r_reads + lbd_pkg::LEN_W'(r_pend)) == r_emits))
        else $error("copy reads and emits out of step");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.done |-> (o_emit.vld && o_emit.last))
        else $error("stream done flagged on a byte that is not last");

    a_copy_no_ring_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> !o_ring_cmd.restart && !o_in_ready)
        else $error("ring restart or input accepted during a copy");
`endif

endmodule

// ===== design/lzss_block_decompressor_top.sv =====
// Top level of the block-framed LZSS decompressor: parser, ring memory, output register.
// Depends on lbd_pkg, lbd_ring and lbd_parser.
//
//   Channel   Signals                                        Direction
//   -------   --------------------------------------------   ---------
//   input     i_in_valid, o_in_ready, i_in_byte               in
//   output    o_out_valid, i_out_ready, o_out_byte,           out
//             o_last_of_run, o_stream_done
//   config    i_cfg_we, i_cfg_data (total_length)             in
//
// Header, flag, stored and literal bytes are taken while the output register has room.
// A match token's second byte starts a copy of 3 to 18 bytes, during which input is held;
// each is read from the registered ring memory, one output byte per cycle unless stalled.
// Reset is synchronous; the ring needs no clearing pass, a fill count marks live entries.
// A stalled output holds the parser and the copy; the input is taken while the
// output register is empty or being emptied in the same cycle.
module lzss_block_decompressor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run,
    output logic                            o_stream_done,
    input  logic                            i_cfg_we,
    input  logic [lbd_pkg::COUNT_BITS-1:0]  i_cfg_data
);

    lbd_pkg::t_ring_cmd ring_cmd;
    lbd_pkg::t_emit     emit;
    logic [7:0]         ring_data;
    logic               can_emit;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_done;

    assign can_emit = !r_out_valid || i_out_ready;

    lbd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_can_emit  (can_emit),
        .i_ring_data (ring_data),
        .o_ring_cmd  (ring_cmd),
        .o_emit      (emit)
    );

    lbd_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ring_cmd),
        .o_rd_data (ring_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.vld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.vld) begin
            r_out_byte <= emit.data;
            r_out_last <= emit.last;
            r_out_done <= emit.done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_byte))
        else $error("output transaction dropped or changed while stalled");

    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_done) |-> o_last_of_run)
        else $error("stream done without last of run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.vld |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

// ===== tb/lbd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the LZSS block decompressor: watches the input, output and config ports,
// predicts every output byte and compares it on arrival. Depends on lbd_pkg.
module lbd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [7:0]                      i_out_byte,
    input  logic                            i_last_of_run,
    input  logic                            i_stream_done,
    input  logic                            i_cfg_we,
    input  logic [lbd_pkg::COUNT_BITS-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_stream_ends
);
    import lbd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_STORED,
        PH_FLAGS,
        PH_TOKEN,
        PH_MATCH_HI
    } parse_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_byte_t;

    localparam int PRINT_LIMIT = 30;

    logic [7:0]            ring_mem [RING_DEPTH];
    logic [RING_AW-1:0]    wr_pos;
    parse_phase_e          phase;
    logic [REM_W-1:0]      blk_left;
    logic [15:0]           flag_bits;
    logic [7:0]            held;
    logic [COUNT_BITS-1:0] out_total;
    logic [COUNT_BITS-1:0] total_len;
    logic [7:0]            run_bytes [$];
    out_byte_t             expected_q [$];

    task automatic report_mismatch(input string what);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH at output byte %0d: %s", $time, o_result_count, what);
        end
        o_fail_count++;
    endtask

    task automatic restart_ring();
        foreach (ring_mem[i]) begin
            ring_mem[i] = SPACE_CHAR;
        end
        wr_pos    = RING_START;
        flag_bits = '0;
    endtask

    task automatic reset_model();
        restart_ring();
        phase     = PH_HDR_HI;
        blk_left  = '0;
        held      = '0;
        out_total = '0;
        total_len = '0;
        expected_q.delete();
    endtask

    // Every decoded byte of a compressed block goes to the ring and to the output.
    task automatic ring_append(input logic [7:0] c);
        ring_mem[wr_pos] = c;
        wr_pos = wr_pos + 1'b1;
        run_bytes.push_back(c);
    endtask

    task automatic start_token(input logic [7:0] b);
        if (flag_bits[0]) begin
            ring_append(b);
            phase = PH_FLAGS;
        end else begin
            held  = b;
            phase = PH_MATCH_HI;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0]        shifted;
        logic [RING_AW-1:0] src;
        int                 n;
        logic               in_block;
        logic               blk_end;
        out_byte_t          rec;
        run_bytes.delete();
        in_block = 1'b1;
        blk_end  = 1'b0;
        case (phase)
            PH_HDR_HI: begin
                in_block = 1'b0;
                // Once the expected total has been produced, header bytes are dropped.
                if (out_total < total_len) begin
                    held  = b;
                    phase = PH_HDR_LO;
                end
            end
            PH_HDR_LO: begin
                in_block = 1'b0;
                blk_left = {held[6:0], b};
                if (!held[7]) begin
                    restart_ring();
                end
                if (blk_left == '0) begin
                    phase = PH_HDR_HI;
                end else begin
                    phase = held[7] ? PH_STORED : PH_FLAGS;
                end
            end
            PH_STORED: begin
                run_bytes.push_back(b);
            end
            PH_FLAGS: begin
                shifted = flag_bits >> 1;
                if (!shifted[8]) begin
                    // All eight flags used up, so this byte carries the next eight.
                    flag_bits = {8'hFF, b};
                    phase     = PH_TOKEN;
                end else begin
                    flag_bits = shifted;
                    start_token(b);
                end
            end
            PH_TOKEN: begin
                start_token(b);
            end
            PH_MATCH_HI: begin
                src = {b[7:4], held};
                n   = int'(b[3:0]) + MATCH_BIAS;
                // Byte by byte, so a source that overlaps the destination sees new data.
                for (int k = 0; k < n; k++) begin
                    ring_append(ring_mem[src]);
                    src = src + 1'b1;
                end
                phase = PH_FLAGS;
            end
            default: begin
                in_block = 1'b0;
                phase    = PH_HDR_HI;
            end
        endcase

        if (in_block) begin
            blk_left = blk_left - 1'b1;
            if (blk_left == '0) begin
                phase   = PH_HDR_HI;
                blk_end = 1'b1;
            end
        end
        foreach (run_bytes[i]) begin
            if (out_total != COUNT_MAX) begin
                out_total = out_total + 1'b1;
            end
        end
        foreach (run_bytes[i]) begin
            rec.data = run_bytes[i];
            rec.last = (i == run_bytes.size() - 1);
            rec.done = rec.last && blk_end && (out_total >= total_len);
            expected_q.push_back(rec);
        end
    endtask

    task automatic check_result();
        out_byte_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte %02h", i_out_byte));
        end else begin
            want = expected_q.pop_front();
            if (i_out_byte !== want.data) begin
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          i_out_byte, want.data));
            end
            if (i_last_of_run !== want.last) begin
                report_mismatch($sformatf("last_of_run %b, expected %b",
                                          i_last_of_run, want.last));
            end
            if (i_stream_done !== want.done) begin
                report_mismatch($sformatf("stream_done %b, expected %b",
                                          i_stream_done, want.done));
            end
        end
        if (i_stream_done === 1'b1) begin
            o_stream_ends++;
        end
        o_result_count++;
    endtask

    // The output transaction of an edge always belongs to an earlier input byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                total_len = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/tb_lzss_block_decompressor_top.sv =====
`timescale 1ns / 1ps
// Testbench top for lzss_block_decompressor_top: clock, reset, block-framed stimulus
// and verdict. Depends on lbd_pkg, the decompressor RTL and lbd_checker.
module tb_lzss_block_decompressor_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 100;

    localparam int CUT_NONE       = 0;
    localparam int CUT_MATCH      = 1;
    localparam int CUT_AFTER_FLAG = 2;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic [7:0]                     in_byte     = 8'h00;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [7:0]                     out_byte;
    logic                           last_of_run;
    logic                           stream_done;
    logic                           cfg_we      = 1'b0;
    logic [lbd_pkg::COUNT_BITS-1:0] cfg_data    = '0;

    int                             fail_count;
    int                             pending;
    int                             result_count;
    int                             stream_ends;

    logic [7:0]                     blk_q [$];
    int                             blk_out;
    int                             gen_out     = 0;
    logic [lbd_pkg::COUNT_BITS-1:0] cur_total   = '0;
    int                             items_sent  = 0;
    int                             live_items  = 0;
    int                             phases      = 0;
    logic                           burst       = 1'b0;
    int                             stall_left  = 0;
    int                             idle_cycles = 0;

    lzss_block_decompressor_top u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (out_byte),
        .o_last_of_run (last_of_run),
        .o_stream_done (stream_done),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data)
    );

    lbd_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_byte     (out_byte),
        .i_last_of_run  (last_of_run),
        .i_stream_done  (stream_done),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_stream_ends  (stream_ends)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_flag();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Mostly recent history at short distances, so many copies overlap themselves.
    function automatic logic [lbd_pkg::RING_AW-1:0] pick_source(
        input logic [lbd_pkg::RING_AW-1:0] wp
    );
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return wp - lbd_pkg::RING_AW'($urandom_range(1, 20));
        if (r < 8) return lbd_pkg::RING_START + lbd_pkg::RING_AW'($urandom_range(0, 40));
        return lbd_pkg::RING_AW'($urandom);
    endfunction

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!burst && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("lzss_block_decompressor_top test failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_block();
        // The block is decoded only if the stream is still short of the total at its header.
        if (gen_out < cur_total) begin
            gen_out += blk_out;
            live_items += blk_q.size();
        end
        foreach (blk_q[i]) begin
            send_byte(blk_q[i]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_total(input logic [lbd_pkg::COUNT_BITS-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_total = v;
        phases++;
    endtask

    task automatic build_stored(input logic [14:0] len);
        blk_q.delete();
        blk_q.push_back({1'b1, len[14:8]});
        blk_q.push_back(len[7:0]);
        repeat (len) blk_q.push_back(8'($urandom));
        blk_out = len;
    endtask

    task automatic build_compressed(input int n_tokens, input int cut);
        logic [7:0]                  body [$];
        logic [lbd_pkg::RING_AW-1:0] wp;
        logic [lbd_pkg::RING_AW-1:0] src;
        logic [3:0]                  nib;
        logic [7:0]                  flag;
        logic [14:0]                 len;
        int                          flag_at;
        blk_out = 0;
        wp      = lbd_pkg::RING_START;
        flag    = 8'h00;
        flag_at = 0;
        if (cut == CUT_AFTER_FLAG) begin
            n_tokens = (n_tokens / 8) * 8;
        end
        for (int t = 0; t < n_tokens; t++) begin
            if (t % 8 == 0) begin
                flag    = pick_flag();
                flag_at = body.size();
                body.push_back(flag);
            end
            if (flag[t % 8]) begin
                body.push_back(8'($urandom));
                wp = wp + 1'b1;
                blk_out++;
            end else begin
                src = pick_source(wp);
                nib = 4'($urandom);
                body.push_back(src[7:0]);
                body.push_back({src[11:8], nib});
                wp = wp + lbd_pkg::RING_AW'(nib + lbd_pkg::MATCH_BIAS);
                blk_out += nib + lbd_pkg::MATCH_BIAS;
            end
        end
        if (cut == CUT_AFTER_FLAG) begin
            body.push_back(pick_flag());
        end else if (cut == CUT_MATCH) begin
            // Make the next token a match and end the block after its first byte.
            if (n_tokens % 8 == 0) begin
                body.push_back(pick_flag() & 8'hFE);
            end else begin
                body[flag_at] = body[flag_at] & ~(8'h01 << (n_tokens % 8));
            end
            body.push_back(8'($urandom));
        end
        len = 15'(body.size());
        blk_q.delete();
        blk_q.push_back({1'b0, len[14:8]});
        blk_q.push_back(len[7:0]);
        foreach (body[i]) begin
            blk_q.push_back(body[i]);
        end
    endtask

    task automatic build_random_block();
        int r;
        int c;
        r = $urandom_range(0, 19);
        c = $urandom_range(0, 9);
        if (r < 2) begin
            build_stored(15'd0);
        end else if (r == 2) begin
            build_compressed(0, CUT_NONE);
        end else if (r < 6) begin
            build_stored(15'($urandom_range(1, 24)));
        end else begin
            build_compressed($urandom_range(1, 24),
                             (c < 6) ? CUT_NONE : (c < 8) ? CUT_MATCH : CUT_AFTER_FLAG);
        end
    endtask

    initial begin
        int r;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // The length register is still zero, so this header is dropped.
        blk_q = '{8'h80, 8'h05};
        blk_out = 0;
        send_block();
        set_total(24'd25);
        blk_q = '{8'h80, 8'h00};
        send_block();
        blk_q = '{8'h00, 8'h00};
        send_block();
        blk_q = '{8'h80, 8'h03, 8'h00, 8'hFF, 8'hA5};
        blk_out = 3;
        send_block();
        blk_q = '{8'h00, 8'h01, 8'hFF};
        blk_out = 0;
        send_block();
        // A literal, an 18-byte copy from one entry behind that wraps the ring, a copy
        // from entry 0, then a match cut after its first byte. This reaches the total.
        blk_q = '{8'h00, 8'h07, 8'h01, 8'h41, 8'hEE, 8'hFF, 8'h00, 8'h00, 8'h5A};
        blk_out = 22;
        send_block();
        blk_q = '{8'h12, 8'h34};
        blk_out = 0;
        send_block();

        set_total('0);
        build_stored(15'd4);
        send_block();

        live_items = 0;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                set_total('0);
            end else if (r == 1) begin
                set_total(lbd_pkg::COUNT_MAX);
            end else begin
                set_total(lbd_pkg::COUNT_BITS'(gen_out + $urandom_range(1, 80)));
            end
            burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                if (items_sent < RANDOM_ITEMS) begin
                    build_random_block();
                    send_block();
                end
            end
        end

        drain();
        $display("Sent %0d input transactions under %0d length settings, %0d of them in",
                 items_sent, phases, live_items);
        $display("decoded random blocks; checked %0d output bytes, %0d closing a stream.",
                 result_count, stream_ends);
        if (fail_count == 0) begin
            $display("lzss_block_decompressor_top test passed");
        end else begin
            $display("lzss_block_decompressor_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lbd_pkg.sv
design/lbd_ring.sv
design/lbd_parser.sv
design/lzss_block_decompressor_top.sv
tb/lbd_checker.sv
tb/tb_lzss_block_decompressor_top.sv
